>>> src/sem_pkg.sv
// ---------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Holds configuration codes, field widths, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package sem_pkg;

    // Default size limits of the frame.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration register fields.
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;
    localparam logic [CFG_W_BITS-1:0] CFG_W_RESET = CFG_W_BITS'(640);
    localparam logic [CFG_H_BITS-1:0] CFG_H_RESET = CFG_H_BITS'(480);

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Pixel and arithmetic widths.
    localparam int CH_BITS   = 8;
    localparam int PIX_BITS  = 24;
    localparam int GRAD_BITS = 12;
    localparam int SUM_BITS  = 22;
    localparam int PROD_BITS = 16;

    // Input mode codes.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CLAMP,
        S_DIV,
        S_READ,
        S_SHIFT,
        S_GRAD,
        S_SQR,
        S_ROOT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic prep;
        logic clamp;
        logic div_step;
        logic shift;
        logic grad;
        logic sqr;
        logic root_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic skip;
        logic emit;
        logic root_done;
    } t_status;

endpackage

>>> src/sem_in_if.sv
// ---------------------------------------------------------------------------
// sem_in_if: input pixel channel
// Carries one pixel or drain tick per beat with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface sem_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

>>> src/sem_out_if.sv
// ---------------------------------------------------------------------------
// sem_out_if: output edge channel
// Carries one edge magnitude result per beat with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface sem_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       last_of_frame;

    modport source (output valid, red_edge, green_edge, blue_edge, last_of_frame,
                    input ready);
    modport sink (input valid, red_edge, green_edge, blue_edge, last_of_frame,
                  output ready);
endinterface

>>> src/sobel_edge_magnitude_rgb.sv
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel edge magnitude, RGB
// Top level joining the controller and the datapath.
// ---------------------------------------------------------------------------
// Each beat on i_pix is accepted and its line store read is done; a drain beat
// ignored during the pixel phase ends there. A beat that produces no result
// adds the window shift, and one that does continues with the window shift,
// gradient, square, eight root search steps, the end of the root search and
// the output load, since the controller works on one beat at a time; a
// stalled receiver holds the block in the output load. The first beat offered
// after reset or after configuration writes waits while row and column are
// recovered from the raster position with a serial divider over PW bits (PW =
// bits of the largest raster position, 23 by default). The result for pixel (r,c)
// leaves when raster position r*W+c+W+1 arrives; W+1 drain beats flush the
// frame, and last_of_frame marks its final result. Pixels outside the frame
// count as zero.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    sem_in_if.sink                   i_pix,
    sem_out_if.source                o_edge
);
    t_cmd    cmd;
    t_status status;

    // Controller.
    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_out_ready(o_edge.ready),
        .o_out_valid(o_edge.valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    sem_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_mode    (i_pix.mode),
        .i_red     (i_pix.red_in),
        .i_green   (i_pix.green_in),
        .i_blue    (i_pix.blue_in),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_red     (o_edge.red_edge),
        .o_green   (o_edge.green_edge),
        .o_blue    (o_edge.blue_edge),
        .o_last    (o_edge.last_of_frame)
    );
endmodule

>>> src/sem_ram.sv
// ---------------------------------------------------------------------------
// sem_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/sem_ctrl.sv
// ---------------------------------------------------------------------------
// sem_ctrl: controller of the Sobel edge block
// Sequences geometry setup, position recovery and the per-beat work.
// ---------------------------------------------------------------------------
module sem_ctrl
    import sem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_recalc, n_recalc;
    logic   r_out_valid, n_out_valid;

    // Next state. The geometry is recomputed only when a beat is offered, so
    // that a group of register writes takes effect as a whole.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_recalc ? S_PREP : S_READ;
                end
            end
            S_PREP:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_READ:  n_state = i_status.skip ? S_IDLE : S_SHIFT;
            S_SHIFT: n_state = i_status.emit ? S_GRAD : S_IDLE;
            S_GRAD:  n_state = S_SQR;
            S_SQR:   n_state = S_ROOT;
            S_ROOT: begin
                if (i_status.root_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = !r_recalc;
                o_cmd.accept = !r_recalc && i_in_valid;
            end
            S_PREP:  o_cmd.prep = 1'b1;
            S_CLAMP: o_cmd.clamp = 1'b1;
            S_DIV:   o_cmd.div_step = !i_status.div_done;
            S_SHIFT: o_cmd.shift = 1'b1;
            S_GRAD:  o_cmd.grad = 1'b1;
            S_SQR:   o_cmd.sqr = 1'b1;
            S_ROOT:  o_cmd.root_step = !i_status.root_done;
            S_OUT:   o_cmd.out_load = !r_out_valid || i_out_ready;
            default: o_cmd = '0;
        endcase
    end

    // Geometry recompute request and output beat flag.
    always_comb begin
        n_recalc = r_recalc;
        if (r_state == S_PREP) begin
            n_recalc = 1'b0;
        end
        if (i_cfg_we) begin
            n_recalc = 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_recalc    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_recalc    <= n_recalc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

>>> src/sem_dp.sv
// ---------------------------------------------------------------------------
// sem_dp: datapath of the Sobel edge block
// Line stores, 3x3 window, raster position, gradients and rounded root.
// ---------------------------------------------------------------------------
module sem_dp
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_mode,
    input  logic [CH_BITS-1:0]       i_red,
    input  logic [CH_BITS-1:0]       i_green,
    input  logic [CH_BITS-1:0]       i_blue,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic [CH_BITS-1:0]       o_red,
    output logic [CH_BITS-1:0]       o_green,
    output logic [CH_BITS-1:0]       o_blue,
    output logic                     o_last
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int DCW = $clog2(PW);

    // Configuration registers.
    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W_RESET;
            r_cfg_h <= CFG_H_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry with clamping of zero and oversize values.
    logic [WW-1:0] w_eff, r_w;
    logic [HW-1:0] h_eff, r_h;
    logic [PW-1:0] r_total, r_endpos, endpos_c;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
        endpos_c = r_total + PW'(r_w);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_w     <= w_eff;
            r_h     <= h_eff;
            r_total <= PW'(w_eff * h_eff);
        end
        if (i_cmd.clamp) begin
            r_endpos <= endpos_c;
        end
    end

    // Raster position, row and column.
    logic [PW-1:0] r_pos;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_col;

    // Restoring divider that recovers row and column from the position.
    logic [WW-1:0]  r_rem, rem_n;
    logic [PW-1:0]  r_quo, quo_n;
    logic [DCW-1:0] r_dcnt;
    logic           r_div_done;
    logic [WW:0]    rem2;
    logic           ge;

    always_comb begin
        rem2  = {r_rem, r_quo[PW-1]};
        ge    = rem2 >= {1'b0, r_w};
        rem_n = ge ? WW'(rem2 - {1'b0, r_w}) : WW'(rem2);
        quo_n = {r_quo[PW-2:0], ge};
    end

    // Beat registers.
    logic                r_mode;
    logic [PIX_BITS-1:0] r_pix;
    logic [PIX_BITS-1:0] pix_eff;
    logic                in_pixels;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_pix  <= {i_red, i_green, i_blue};
        end
    end

    assign in_pixels = r_pos < r_total;
    assign pix_eff   = (r_mode == MODE_DRAIN || !in_pixels) ? '0 : r_pix;

    // Line stores.
    logic [PIX_BITS-1:0] top_rd, mid_rd;

    sem_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk  (i_clk),
        .i_we   (i_cmd.shift),
        .i_waddr(r_col),
        .i_wdata(mid_rd),
        .i_raddr(r_col),
        .o_rdata(top_rd)
    );

    sem_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk  (i_clk),
        .i_we   (i_cmd.shift),
        .i_waddr(r_col),
        .i_wdata(pix_eff),
        .i_raddr(r_col),
        .o_rdata(mid_rd)
    );

    // Window shift, neighbor selection and edge masking.
    logic [PIX_BITS-1:0] r_win [9];
    logic [PIX_BITS-1:0] win_n [9];
    logic [PIX_BITS-1:0] nb_sel [9];
    logic [PIX_BITS-1:0] r_nb [9];
    logic                past, col0, emit_a, is_last;
    logic [RW-1:0]       crow;
    logic                top_out, bot_out, left_out, right_out;
    logic [WW-1:0]       col_inc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_n[i*3]     = r_win[i*3+1];
            win_n[i*3+1]   = r_win[i*3+2];
        end
        win_n[2] = top_rd;
        win_n[5] = mid_rd;
        win_n[8] = pix_eff;

        past    = r_pos >= PW'(r_w) + PW'(1);
        col0    = r_col == '0;
        emit_a  = col0 && past;
        is_last = r_pos == r_endpos;
        col_inc = WW'(r_col) + WW'(1);

        if (emit_a) begin
            for (int i = 0; i < 3; i++) begin
                nb_sel[i*3]   = r_win[i*3+1];
                nb_sel[i*3+1] = r_win[i*3+2];
                nb_sel[i*3+2] = '0;
            end
            crow      = r_row - RW'(2);
            left_out  = r_w == WW'(1);
            right_out = 1'b1;
        end else begin
            for (int k = 0; k < 9; k++) begin
                nb_sel[k] = win_n[k];
            end
            crow      = r_row - RW'(1);
            left_out  = r_col == AW'(1);
            right_out = 1'b0;
        end
        top_out = crow == '0;
        bot_out = 32'(crow) + 32'd1 == 32'(r_h);
    end

    // Sequenced register updates of window, position and divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_div_done <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cmd.clamp) begin
                r_rem      <= '0;
                r_quo      <= (r_pos > endpos_c) ? '0 : r_pos;
                r_dcnt     <= DCW'(PW - 1);
                r_div_done <= 1'b0;
                if (r_pos > endpos_c) begin
                    r_pos <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_rem  <= rem_n;
                r_quo  <= quo_n;
                r_dcnt <= r_dcnt - DCW'(1);
                if (r_dcnt == '0) begin
                    r_row      <= RW'(quo_n);
                    r_col      <= AW'(rem_n);
                    r_div_done <= 1'b1;
                end
            end
            if (i_cmd.shift) begin
                for (int k = 0; k < 9; k++) begin
                    r_win[k] <= win_n[k];
                end
                if (past && is_last) begin
                    r_pos <= '0;
                    r_row <= '0;
                    r_col <= '0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                    if (col_inc == r_w) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= AW'(col_inc);
                    end
                end
            end
        end
    end

    // Masked neighborhood and end-of-frame flag.
    logic r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && top_out) || (i == 2 && bot_out) ||
                        (j == 0 && left_out) || (j == 2 && right_out)) begin
                        r_nb[i*3+j] <= '0;
                    end else begin
                        r_nb[i*3+j] <= nb_sel[i*3+j];
                    end
                end
            end
            r_last <= is_last;
        end
    end

    // Gradients per channel.
    logic signed [GRAD_BITS-1:0] gx_c [3], gy_c [3];
    logic signed [GRAD_BITS-1:0] r_gx [3], r_gy [3];
    logic signed [GRAD_BITS-1:0] v [9];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                v[k] = $signed({4'b0, r_nb[k][(2-ch)*CH_BITS +: CH_BITS]});
            end
            gx_c[ch] = v[2] - v[0] + (v[5] <<< 1) - (v[3] <<< 1) + v[8] - v[6];
            gy_c[ch] = v[6] - v[0] + (v[7] <<< 1) - (v[1] <<< 1) + v[8] - v[2];
        end
    end

    // Squared magnitude and rounded square root by binary search.
    logic [SUM_BITS-1:0] r_sum [3];
    logic [CH_BITS-1:0]  r_res [3];
    logic [CH_BITS-1:0]  cand [3];
    logic [PROD_BITS-1:0] prod [3];
    logic [2:0]          r_rbit;
    logic                r_root_done;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cand[ch] = r_res[ch] | (CH_BITS'(1) << r_rbit);
            prod[ch] = PROD_BITS'(cand[ch] * (cand[ch] - CH_BITS'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_gx[ch] <= gx_c[ch];
                r_gy[ch] <= gy_c[ch];
            end
        end
        if (i_cmd.sqr) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_sum[ch] <= SUM_BITS'(r_gx[ch] * r_gx[ch]) +
                             SUM_BITS'(r_gy[ch] * r_gy[ch]);
                r_res[ch] <= '0;
            end
            r_rbit      <= 3'd7;
            r_root_done <= 1'b0;
        end
        if (i_cmd.root_step) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (SUM_BITS'(prod[ch]) < r_sum[ch]) begin
                    r_res[ch] <= cand[ch];
                end
            end
            r_rbit <= r_rbit - 3'd1;
            if (r_rbit == 3'd0) begin
                r_root_done <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_red   <= r_res[0];
            o_green <= r_res[1];
            o_blue  <= r_res[2];
            o_last  <= r_last;
        end
    end

    assign o_status.div_done  = r_div_done;
    assign o_status.skip      = r_mode == MODE_DRAIN && in_pixels;
    assign o_status.emit      = past;
    assign o_status.root_done = r_root_done;
endmodule

>>> dv/sobel_edge_magnitude_rgb_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_tb: self-checking bench of the RGB Sobel block
// Streams frames of random and extreme size and content through the block,
// predicts every edge magnitude beat with a model of the line stores and the
// 3x3 window, and compares each output beat field by field. Sender gaps and
// receiver stalls vary across four phases.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb;
    import sem_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_mag;

    // One row of the directed table: a register write or an input beat.
    typedef struct {
        bit                     is_cfg;
        bit [CFG_IDX_BITS-1:0]  idx;
        bit [CFG_DATA_BITS-1:0] val;
        bit                     mode;
        bit [23:0]              pix;
        bit                     typed;
        t_mag                   mag;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    sem_in_if  pix_if ();
    sem_out_if edge_if ();

    sobel_edge_magnitude_rgb u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_if),
        .o_edge    (edge_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: registers, line stores, window and raster position.
    int unsigned cfg_width = 640;
    int unsigned cfg_height = 480;
    logic [23:0] row_upper [MAX_WIDTH_DEF];
    logic [23:0] row_middle [MAX_WIDTH_DEF];
    logic [23:0] window [9];
    int unsigned raster_pos = 0;

    t_mag pending_mags [$];
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    t_mag typed_mag;
    bit   use_typed = 0;

    // Rounded square root, saturated at 255.
    function automatic logic [7:0] round_root(int unsigned s);
        int unsigned n;
        round_root = 0;
        for (n = 1; n <= 255; n++) begin
            if (n * (n - 1) < s) round_root = n[7:0];
        end
    endfunction

    // Sobel magnitude of one channel of a masked 3x3 neighborhood.
    function automatic logic [7:0] channel_mag(logic [23:0] nb [3][3], int sh);
        int v [3][3];
        int gx, gy;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) v[i][j] = (nb[i][j] >> sh) & 8'hff;
        gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
        gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
        return round_root(gx * gx + gy * gy);
    endfunction

    // Advance the window model by one accepted beat and queue any result.
    task automatic sobel_step(input logic mode, input logic [23:0] px);
        int unsigned w, hgt, total, endp, q, rq, cq;
        int cr, cc, r, c;
        logic [23:0] pix;
        logic [23:0] nb [3][3];
        bit emit;
        t_mag m;
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : cfg_width);
        hgt = (cfg_height == 0) ? 1
            : (cfg_height > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : cfg_height);
        total = w * hgt;
        endp = total + w;
        if (raster_pos > endp) raster_pos = 0;
        q = raster_pos;
        // A drain beat is ignored while pixels are still due.
        if (mode == MODE_DRAIN && q < total) return;
        pix = (mode == MODE_PIXEL && q < total) ? px : 24'h0;
        rq = q / w;
        cq = q % w;
        emit = 0;
        // At a row start the centre is the last column of the row before.
        if (cq == 0 && q >= w + 1) begin
            for (int i = 0; i < 3; i++) begin
                nb[i][0] = window[i * 3 + 1];
                nb[i][1] = window[i * 3 + 2];
                nb[i][2] = 24'h0;
            end
            cr = int'(rq) - 2;
            cc = int'(w) - 1;
            emit = 1;
        end
        for (int i = 0; i < 3; i++) begin
            window[i * 3 + 0] = window[i * 3 + 1];
            window[i * 3 + 1] = window[i * 3 + 2];
        end
        window[2] = row_upper[cq];
        window[5] = row_middle[cq];
        window[8] = pix;
        row_upper[cq] = row_middle[cq];
        row_middle[cq] = pix;
        if (cq != 0 && q >= w + 1) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) nb[i][j] = window[i * 3 + j];
            cr = int'(rq) - 1;
            cc = int'(cq) - 1;
            emit = 1;
        end
        if (!emit) begin
            raster_pos = q + 1;
            return;
        end
        // Neighbors outside the frame count as zero.
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                r = cr - 1 + i;
                c = cc - 1 + j;
                if (r < 0 || r >= int'(hgt) || c < 0 || c >= int'(w)) nb[i][j] = 24'h0;
            end
        m.red = channel_mag(nb, 16);
        m.green = channel_mag(nb, 8);
        m.blue = channel_mag(nb, 0);
        m.last = (q == endp);
        pending_mags.push_back(use_typed ? typed_mag : m);
        raster_pos = (q == endp) ? 0 : q + 1;
    endtask

    // Offer one beat with random sender gaps; predict once it is taken.
    task automatic send_beat(input logic mode, input logic [23:0] px);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.mode <= mode;
        pix_if.red_in <= px[23:16];
        pix_if.green_in <= px[15:8];
        pix_if.blue_in <= px[7:0];
        do begin
            @(negedge i_clk);
            taken = pix_if.ready;
            @(posedge i_clk);
        end while (!taken);
        sobel_step(mode, px);
    endtask

    // Hold the sender off until every queued result has come out.
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_mags.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IDX_WIDTH) cfg_width = val & 13'h7ff;
        else cfg_height = val;
    endtask

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        p = $urandom;
        // Bias some channels to the extremes to reach saturation.
        for (int k = 0; k < 3; k++)
            if ($urandom_range(3) == 0) p[k * 8 +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
        return p;
    endfunction

    // One frame of the given size; noise drain beats sometimes fall in the
    // pixel phase, and drain slots are sometimes filled with pixel beats.
    task automatic run_frame(input int w, input int hgt, input bit noisy);
        for (int k = 0; k < w * hgt; k++) begin
            if (noisy && $urandom_range(15) == 0) send_beat(MODE_DRAIN, rand_pixel());
            send_beat(MODE_PIXEL, rand_pixel());
        end
        for (int k = 0; k <= w; k++)
            send_beat((noisy && $urandom_range(5) == 0) ? MODE_PIXEL : MODE_DRAIN, rand_pixel());
    endtask

    // Output side: random stalls, sample at the falling edge, check at the rise.
    initial begin
        bit   got;
        t_mag seen, want;
        got = 0;
        edge_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (got) begin
                if (pending_mags.size() == 0) begin
                    $error("unexpected edge beat %h", seen);
                    fail_count++;
                end else begin
                    want = pending_mags.pop_front();
                    if (seen.red !== want.red) begin
                        $error("red_edge expected %0d got %0d", want.red, seen.red);
                        fail_count++;
                    end
                    if (seen.green !== want.green) begin
                        $error("green_edge expected %0d got %0d", want.green, seen.green);
                        fail_count++;
                    end
                    if (seen.blue !== want.blue) begin
                        $error("blue_edge expected %0d got %0d", want.blue, seen.blue);
                        fail_count++;
                    end
                    if (seen.last !== want.last) begin
                        $error("last_of_frame expected %0d got %0d", want.last, seen.last);
                        fail_count++;
                    end
                end
            end
            edge_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            @(negedge i_clk);
            got = edge_if.valid && edge_if.ready;
            seen = {edge_if.red_edge, edge_if.green_edge, edge_if.blue_edge,
                    edge_if.last_of_frame};
        end
    end

    // Directed table: 1x1 frames, a 3x2 checkerboard, a mid-frame resize and
    // zero-sized registers.
    t_row directed [] = '{
        '{1, CFG_IDX_WIDTH,  1, 0, 0, 0, 0},
        '{1, CFG_IDX_HEIGHT, 1, 0, 0, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 24'h000000, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 24'h000000, 1, 25'h1},
        '{0, 0, 0, MODE_PIXEL, 24'h000000, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'h123456, 1, 25'h1},
        '{1, CFG_IDX_WIDTH,  3, 0, 0, 0, 0},
        '{1, CFG_IDX_HEIGHT, 2, 0, 0, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'h000000, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'h000000, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'h000000, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hffffff, 0, 0},
        '{1, CFG_IDX_WIDTH,  1, 0, 0, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'hff0000, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'h00ff00, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{1, CFG_IDX_WIDTH,  0, 0, 0, 0, 0},
        '{1, CFG_IDX_HEIGHT, 0, 0, 0, 0, 0},
        '{0, 0, 0, MODE_PIXEL, 24'habcdef, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 0, 0},
        '{0, 0, 0, MODE_DRAIN, 0, 1, 25'h1}
    };

    initial begin
        int w, hgt;
        pix_if.valid = 1'b0;
        pix_if.mode = MODE_PIXEL;
        pix_if.red_in = '0;
        pix_if.green_in = '0;
        pix_if.blue_in = '0;
        foreach (window[k]) window[k] = '0;
        foreach (row_upper[k]) begin
            row_upper[k] = '0;
            row_middle[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                wait_drained();
                write_reg(directed[k].idx, directed[k].val);
            end else begin
                use_typed = directed[k].typed;
                typed_mag = directed[k].mag;
                send_beat(directed[k].mode, directed[k].pix);
                use_typed = 0;
            end
        end

        // Register extremes, run without idling to keep the run short. The
        // oversize width is used as the largest one, so results start once a
        // full row and one pixel are in; both frames are cut short by the
        // following resize.
        wait_drained();
        write_reg(CFG_IDX_WIDTH, 2047);
        write_reg(CFG_IDX_HEIGHT, 3);
        for (int k = 0; k < MAX_WIDTH_DEF + 6; k++) send_beat(MODE_PIXEL, rand_pixel());
        wait_drained();
        write_reg(CFG_IDX_WIDTH, 1);
        write_reg(CFG_IDX_HEIGHT, 8191);
        for (int k = 0; k < 24; k++) send_beat(MODE_PIXEL, rand_pixel());

        // Random frames under four idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int sent = 0; sent < 120; ) begin
                wait_drained();
                w = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
                hgt = $urandom_range(6, 1);
                write_reg(CFG_IDX_WIDTH, w);
                write_reg(CFG_IDX_HEIGHT, hgt);
                // Some frames are cut short by a resize once the block is idle.
                if ($urandom_range(9) == 0) begin
                    for (int k = 0; k < $urandom_range(w * hgt); k++)
                        send_beat(MODE_PIXEL, rand_pixel());
                    continue;
                end
                // Back-to-back frames of the same size.
                for (int f = $urandom_range(2); f >= 0; f--) begin
                    run_frame(w, hgt, 1);
                    sent += w * hgt + w + 1;
                end
            end
        end

        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_mags.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sobel_edge_magnitude_rgb test passed");
        end else begin
            $display("sobel_edge_magnitude_rgb test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #50ms;
        $display("sobel_edge_magnitude_rgb test failed");
        $finish;
    end

endmodule
